### rtl/core/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared command codes, engine state encoding and transfer payload types.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // Data bits in one byte on the bus
   localparam int unsigned BITS_PER_BYTE = 8;

   // Operation codes on the request channel (6 and 7 act as a tick)
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;
   localparam logic [2:0] OP_ACK   = 3'd5;

   // Command sequence in progress; values match the operation codes
   typedef enum logic [2:0] {
      CMD_IDLE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4,
      CMD_ACK   = 3'd5
   } cmd_type;

   // One request item
   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] write_data;
      logic       ack_bit;
      logic       sda_sample;
   } req_type;

   // One result item
   typedef struct packed {
      logic       scl_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       nak_received;
      logic       command_rejected;
   } rsp_type;

endpackage

### rtl/core/i2cm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine core
// Holds the command sequencer and line registers; steps one half period per
// transferred request and presents the matching result in the same cycle.
// ----------------------------------------------------------------------------
module i2cm_core
   import i2cm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req_data,
   output rsp_type step_rsp
);

   localparam logic [3:0] BIT_LAST = 4'(BITS_PER_BYTE);

   cmd_type    cmd_ff, cmd_in;
   logic [1:0] phase_ff, phase_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic [7:0] last_read_ff, last_read_in;
   logic       last_nak_ff, last_nak_in;

   logic       is_cmd;
   logic       active;
   logic       last;
   logic       rejected;
   logic       done;

   assign is_cmd = (req_data.operation >= OP_START) && (req_data.operation <= OP_ACK);

   // Advance or load the sequence, drive the lines, then close on the last half
   always_comb begin
      cmd_in       = cmd_ff;
      phase_in     = phase_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      last_read_in = last_read_ff;
      last_nak_in  = last_nak_ff;
      active       = 1'b0;
      last         = 1'b0;
      rejected     = 1'b0;
      done         = 1'b0;

      if (cmd_ff != CMD_IDLE) begin
         rejected = is_cmd;
         active   = 1'b1;
         if (cmd_ff == CMD_WRITE || cmd_ff == CMD_READ) begin
            if (phase_ff == 2'd0) begin
               phase_in = 2'd1;
            end else begin
               // sample SDA at the end of a high half
               if (bit_ff < BIT_LAST) begin
                  shift_in = {shift_ff[6:0], (cmd_ff == CMD_READ) ? req_data.sda_sample : 1'b0};
               end else if (bit_ff == BIT_LAST && cmd_ff == CMD_WRITE) begin
                  last_nak_in = req_data.sda_sample;
               end
               bit_in   = bit_ff + 4'd1;
               phase_in = 2'd0;
            end
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end else if (is_cmd) begin
         active   = 1'b1;
         cmd_in   = cmd_type'(req_data.operation);
         phase_in = 2'd0;
         bit_in   = 4'd0;
         if (req_data.operation == OP_WRITE) begin
            shift_in = req_data.write_data;
         end else if (req_data.operation == OP_ACK) begin
            shift_in = {7'd0, req_data.ack_bit};
         end else begin
            shift_in = 8'd0;
         end
      end

      // drive the half period of the updated sequence
      if (active) begin
         unique case (cmd_in)
            CMD_START: begin
               scl_in = (phase_in < 2'd2);
               sda_in = (phase_in == 2'd0);
               last   = (phase_in >= 2'd2);
            end
            CMD_STOP: begin
               scl_in = (phase_in >= 2'd1);
               sda_in = (phase_in >= 2'd2);
               last   = (phase_in >= 2'd2);
            end
            CMD_ACK: begin
               scl_in = (phase_in == 2'd1);
               sda_in = shift_in[0];
               last   = (phase_in >= 2'd2);
            end
            CMD_WRITE: begin
               if (bit_in < BIT_LAST) begin
                  scl_in = phase_in[0];
                  sda_in = shift_in[7];
               end else if (bit_in == BIT_LAST) begin
                  scl_in = phase_in[0];
                  sda_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
                  sda_in = 1'b1;
                  last   = 1'b1;
               end
            end
            CMD_READ: begin
               scl_in = (bit_in < BIT_LAST) ? phase_in[0] : 1'b0;
               sda_in = 1'b1;
               last   = (bit_in >= BIT_LAST);
            end
            default: begin
            end
         endcase
      end

      // close the sequence on its last half period
      if (active && last) begin
         if (cmd_in == CMD_READ) begin
            last_read_in = shift_in;
         end
         cmd_in   = CMD_IDLE;
         phase_in = 2'd0;
         bit_in   = 4'd0;
         done     = 1'b1;
      end
   end

   // Hold state between transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= CMD_IDLE;
         phase_ff     <= 2'd0;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'd0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         last_read_ff <= 8'd0;
         last_nak_ff  <= 1'b0;
      end else if (step) begin
         cmd_ff       <= cmd_in;
         phase_ff     <= phase_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         last_read_ff <= last_read_in;
         last_nak_ff  <= last_nak_in;
      end
   end

   // Result of this step
   assign step_rsp.scl_level        = scl_in;
   assign step_rsp.sda_drive        = sda_in;
   assign step_rsp.busy_res         = (cmd_in != CMD_IDLE);
   assign step_rsp.done_res         = done;
   assign step_rsp.read_byte        = last_read_in;
   assign step_rsp.nak_received     = last_nak_in;
   assign step_rsp.command_rejected = rejected;

endmodule

### rtl/core/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine
// Turns start, stop, write, read and ack commands into SCL/SDA half periods,
// one half period per request transfer, with one result per request.
// ----------------------------------------------------------------------------
//   Channel  Dir  Handshake             Payload
//   req      in   req_valid/req_ready   req_data (req_type)
//   rsp      out  rsp_valid/rsp_ready   rsp_data (rsp_type)
//
// One request per cycle while req_ready is high; the result is registered and
// shows the next cycle if rsp is free; only the sequencer update lies between.
// A skid register keeps req_ready high for one more transfer while rsp stalls;
// req_ready drops only when both result registers are full.
// Synchronous reset puts the bus lines released and the sequencer idle.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine
   import i2cm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    req_xfer;
   logic    rsp_free;
   rsp_type step_rsp;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   assign req_ready = !skid_valid_ff;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   i2cm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (req_xfer),
      .req_data (req_data),
      .step_rsp (step_rsp)
   );

   // Route results through the output and skid registers
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (req_xfer) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = step_rsp;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (req_xfer) begin
         skid_valid_in = 1'b1;
         skid_data_in  = step_rsp;
      end
   end

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Hold payloads
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Skid register is filled only behind an occupied output register
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // Skid fills only on a transfer while the output stalls
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(req_valid && rsp_valid_ff && !rsp_ready))
      else $error("skid register filled without a stalled transfer");

   // A finished command leaves the engine idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res |-> !rsp_data_ff.busy_res)
      else $error("done result reports busy");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives start, stop, write, read and ack commands plus ticks on the request
// channel. Every request transfer is run through a local model of the bus
// sequencer, and each response transfer is compared field by field with the
// oldest predicted line state. Both channels idle at random. One long response
// stall fills the engine and stalls its request side.
// ----------------------------------------------------------------------------
module tb_top;
   import i2cm_pkg::*;

   localparam int unsigned TOTAL_ITEMS     = 720;
   localparam int unsigned RSP_HOLD_CYCLES = 64;
   localparam int unsigned WATCHDOG_LIMIT  = 1000;
   localparam int unsigned DRAIN_CYCLES    = 8;
   localparam int unsigned MAX_REPORTS     = 60;

   // Unused operation codes; the engine treats them as a tick
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Local copy of the sequencer state
   cmd_type    eng_cmd;
   logic [1:0] eng_phase;
   logic [3:0] eng_bits;
   logic [7:0] eng_shift;
   logic       eng_scl;
   logic       eng_sda;
   logic [7:0] eng_last_read;
   logic       eng_last_nak;

   rsp_type     predicted_line_q[$];
   rsp_type     line_want;
   int unsigned items_sent       = 0;
   int unsigned rsp_count        = 0;
   int unsigned error_count      = 0;
   bit          req_idle_on      = 1'b1;
   bit          rsp_idle_on      = 1'b1;
   bit          rsp_hold_request = 1'b0;

   i2c_master_bit_engine uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Compute the line state for one accepted half period and queue it
   task automatic predict_half_period(input req_type item);
      logic is_cmd;
      logic rejected;
      logic done;
      logic active;
      logic last;
      rsp_type line;
      is_cmd   = (item.operation >= OP_START) && (item.operation <= OP_ACK);
      rejected = 1'b0;
      done     = 1'b0;
      active   = 1'b0;
      last     = 1'b0;

      if (eng_cmd != CMD_IDLE) begin
         // busy: a command is flagged and ignored, the sequence advances
         rejected = is_cmd;
         active   = 1'b1;
         if (eng_cmd == CMD_WRITE || eng_cmd == CMD_READ) begin
            if (eng_phase == 2'd0) begin
               eng_phase = 2'd1;
            end else begin
               // end of a high half: sample SDA
               if (eng_bits < BITS_PER_BYTE) begin
                  if (eng_cmd == CMD_READ)
                     eng_shift = {eng_shift[6:0], item.sda_sample};
                  else
                     eng_shift = {eng_shift[6:0], 1'b0};
               end else if (eng_bits == BITS_PER_BYTE && eng_cmd == CMD_WRITE) begin
                  eng_last_nak = item.sda_sample;
               end
               eng_bits  = eng_bits + 4'd1;
               eng_phase = 2'd0;
            end
         end else begin
            eng_phase = eng_phase + 2'd1;
         end
      end else if (is_cmd) begin
         // idle: load the command and drive its first half at once
         eng_cmd   = cmd_type'(item.operation);
         eng_phase = 2'd0;
         eng_bits  = 4'd0;
         if (item.operation == OP_WRITE)
            eng_shift = item.write_data;
         else if (item.operation == OP_ACK)
            eng_shift = {7'd0, item.ack_bit};
         else
            eng_shift = 8'd0;
         active = 1'b1;
      end

      if (active) begin
         case (eng_cmd)
            CMD_START: begin
               eng_scl = (eng_phase < 2'd2);
               eng_sda = (eng_phase == 2'd0);
               last    = (eng_phase >= 2'd2);
            end
            CMD_STOP: begin
               eng_scl = (eng_phase >= 2'd1);
               eng_sda = (eng_phase >= 2'd2);
               last    = (eng_phase >= 2'd2);
            end
            CMD_ACK: begin
               eng_scl = (eng_phase == 2'd1);
               eng_sda = eng_shift[0];
               last    = (eng_phase >= 2'd2);
            end
            CMD_WRITE: begin
               if (eng_bits < BITS_PER_BYTE) begin
                  eng_scl = eng_phase[0];
                  eng_sda = eng_shift[7];
               end else if (eng_bits == BITS_PER_BYTE) begin
                  // acknowledge bit: release SDA
                  eng_scl = eng_phase[0];
                  eng_sda = 1'b1;
               end else begin
                  eng_scl = 1'b0;
                  eng_sda = 1'b1;
                  last    = 1'b1;
               end
            end
            CMD_READ: begin
               eng_sda = 1'b1;
               if (eng_bits < BITS_PER_BYTE) begin
                  eng_scl = eng_phase[0];
               end else begin
                  eng_scl = 1'b0;
                  last    = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // last half period: back to idle on the same transfer
      if (last) begin
         if (eng_cmd == CMD_READ)
            eng_last_read = eng_shift;
         eng_cmd   = CMD_IDLE;
         eng_phase = 2'd0;
         eng_bits  = 4'd0;
         done      = 1'b1;
      end

      line.scl_level        = eng_scl;
      line.sda_drive        = eng_sda;
      line.busy_res         = (eng_cmd != CMD_IDLE);
      line.done_res         = done;
      line.read_byte        = eng_last_read;
      line.nak_received     = eng_last_nak;
      line.command_rejected = rejected;
      predicted_line_q.push_back(line);
   endtask

   // Offer one request after a random gap and hold it until the transfer
   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_half_period(item);
      items_sent++;
   endtask

   function automatic req_type make_item(input logic [2:0] op);
      req_type item;
      item.operation  = op;
      item.write_data = 8'($urandom);
      item.ack_bit    = 1'($urandom);
      item.sda_sample = 1'($urandom);
      return item;
   endfunction

   // Mostly ticks, some unused codes, some commands that land while busy
   function automatic logic [2:0] filler_op();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 80)
         return OP_TICK;
      else if (pick < 90)
         return pick[0] ? OP_UNUSED_6 : OP_UNUSED_7;
      else
         return 3'($urandom_range(OP_START, OP_ACK));
   endfunction

   // Finish any running sequence, issue one command and tick it to the end
   task automatic run_command(input logic [2:0] op, input logic [7:0] data,
                              input logic ackb, input bit noisy);
      req_type item;
      while (eng_cmd != CMD_IDLE)
         send_item(make_item(noisy ? filler_op() : OP_TICK));
      item            = make_item(op);
      item.write_data = data;
      item.ack_bit    = ackb;
      send_item(item);
      while (eng_cmd != CMD_IDLE)
         send_item(make_item(noisy ? filler_op() : OP_TICK));
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got_val,
                                  input logic [7:0] want_val);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR at %0t, result %0d, %s: got %h, expected %h",
                  $time, rsp_count, what, got_val, want_val);
   endtask

   // Check each response transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_line_q.size() == 0) begin
            report_mismatch("result with nothing predicted", 8'd0, 8'd0);
         end else begin
            line_want = predicted_line_q.pop_front();
            if (rsp_data.scl_level !== line_want.scl_level)
               report_mismatch("scl_level", 8'(rsp_data.scl_level),
                               8'(line_want.scl_level));
            if (rsp_data.sda_drive !== line_want.sda_drive)
               report_mismatch("sda_drive", 8'(rsp_data.sda_drive),
                               8'(line_want.sda_drive));
            if (rsp_data.busy_res !== line_want.busy_res)
               report_mismatch("busy_res", 8'(rsp_data.busy_res),
                               8'(line_want.busy_res));
            if (rsp_data.done_res !== line_want.done_res)
               report_mismatch("done_res", 8'(rsp_data.done_res),
                               8'(line_want.done_res));
            if (rsp_data.read_byte !== line_want.read_byte)
               report_mismatch("read_byte", rsp_data.read_byte, line_want.read_byte);
            if (rsp_data.nak_received !== line_want.nak_received)
               report_mismatch("nak_received", 8'(rsp_data.nak_received),
                               8'(line_want.nak_received));
            if (rsp_data.command_rejected !== line_want.command_rejected)
               report_mismatch("command_rejected", 8'(rsp_data.command_rejected),
                               8'(line_want.command_rejected));
         end
         rsp_count++;
      end
   end

   // Response side: random stalls, plus one long hold on request
   initial begin : rsp_sink
      int unsigned stall;
      forever begin
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         stall = rsp_idle_on ? $urandom_range(0, 6) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // End the run when no transfer happens for too long
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Idle ticks and unused codes leave the lines released
   task automatic test_idle_ticks();
      send_item(make_item(OP_TICK));
      send_item(make_item(OP_UNUSED_6));
      send_item(make_item(OP_UNUSED_7));
   endtask

   // Start condition with a write command arriving mid-sequence
   task automatic test_start_with_reject();
      send_item(make_item(OP_START));
      send_item(make_item(OP_WRITE));
      send_item(make_item(OP_TICK));
   endtask

   task automatic test_read_byte();
      run_command(OP_READ, 8'h00, 1'b0, 1'b0);
   endtask

   task automatic test_send_nak();
      run_command(OP_ACK, 8'hFF, 1'b1, 1'b0);
   endtask

   task automatic test_stop();
      run_command(OP_STOP, 8'h00, 1'b0, 1'b0);
   endtask

   // Hold the response side while requests keep coming back to back
   task automatic test_backpressure();
      req_idle_on      = 1'b0;
      rsp_hold_request = 1'b1;
      run_command(OP_WRITE, 8'hA5, 1'b0, 1'b0);
      req_idle_on      = 1'b1;
   endtask

   // One bus transaction: start, a few writes or read-plus-ack, then stop
   task automatic random_transaction();
      int unsigned n_cmds;
      n_cmds = $urandom_range(1, 3);
      run_command(OP_START, 8'($urandom), 1'($urandom), 1'b1);
      repeat (n_cmds) begin
         if ($urandom_range(0, 1)) begin
            run_command(OP_WRITE, 8'($urandom), 1'($urandom), 1'b1);
         end else begin
            run_command(OP_READ, 8'($urandom), 1'($urandom), 1'b1);
            run_command(OP_ACK, 8'($urandom), 1'($urandom), 1'b1);
         end
      end
      run_command(OP_STOP, 8'($urandom), 1'($urandom), 1'b1);
   endtask

   task automatic test_random_traffic();
      while (items_sent < TOTAL_ITEMS) begin
         req_idle_on = ($urandom_range(0, 4) != 0);
         rsp_idle_on = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 99) < 85) begin
            random_transaction();
         end else begin
            // raw noise: any operation at any point of a sequence
            repeat ($urandom_range(1, 6))
               send_item(make_item(3'($urandom_range(0, 7))));
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin : test_sequence
      eng_cmd       = CMD_IDLE;
      eng_phase     = 2'd0;
      eng_bits      = 4'd0;
      eng_shift     = 8'd0;
      eng_scl       = 1'b1;
      eng_sda       = 1'b1;
      eng_last_read = 8'd0;
      eng_last_nak  = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_ticks();
      test_start_with_reject();
      test_read_byte();
      test_send_nak();
      test_stop();
      test_backpressure();
      test_random_traffic();

      // drop valid and wait for the last results
      req_valid <= 1'b0;
      while (predicted_line_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && predicted_line_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
